// ----- rtl/core/frame_bitmap_allocator_assert.svh -----
// ============================================================================
// Assertion macros for the frame bitmap allocator
// Immediate-consequence and next-cycle implication checks on clk and rst_n.
// Defining NO_ASSERTIONS turns every check into an empty line.
// ============================================================================
`ifndef FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequence must hold in the same cycle as the antecedent.
`define FBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame bitmap allocator check failed");

// The consequence must hold in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame bitmap allocator check failed");

`else

`define FBA_ASSERT_NOW(label, ante, cons)
`define FBA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/fba_pkg.sv -----
// ============================================================================
// fba_pkg
// Shared constants, request codes and the result record of the allocator.
// ============================================================================
package fba_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int MAX_FRAMES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;
    localparam int PAGE_SHIFT_DEF = 12;

    // Fixed field widths.
    localparam int ADDR_BITS   = 32;
    localparam int FRAME_NUM_W = 12;
    localparam int CFG_W       = 13;
    localparam int KIND_W      = 3;

    localparam logic [CFG_W-1:0] FRAMES_RESET = 13'd4096;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MARK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TEST  = 3'd4;

    typedef struct packed {
        logic [FRAME_NUM_W-1:0] frame_number;
        logic                   present;
        logic                   writable;
        logic                   user_access;
        logic                   page_updated;
        logic                   no_free_frame;
        logic                   frame_used;
    } result_t;

endpackage

// ----- rtl/core/fba_mem.sv -----
// ============================================================================
// fba_mem
// Bitmap word store with registered read and per-word valid bits;
// a word never written since reset reads as all zeros.
// ============================================================================
module fba_mem #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
    parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      rd_en,
    input  logic [((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS > 1 ?
                   $clog2((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] rd_addr,
    output logic [WORD_BITS-1:0]                      rd_data,
    input  logic                                      wr_en,
    input  logic [((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS > 1 ?
                   $clog2((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]                      wr_data
);

    localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;

    logic [WORD_BITS-1:0] bitmap_ram [NUM_WORDS];
    logic [WORD_BITS-1:0] ram_q_reg;
    logic [NUM_WORDS-1:0] valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            ram_q_reg <= bitmap_ram[rd_addr];
        end
    end

    // Valid bits stand in for clearing the array after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? ram_q_reg : '0;

endmodule

// ----- rtl/core/fba_summary.sv -----
// ============================================================================
// fba_summary
// Per-word full flags and a registered priority encoder that finds the lowest
// word below the managed limit that still has a free frame.
// ============================================================================
module fba_summary #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
    parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [$clog2(MAX_FRAMES + 1)-1:0]         limit,
    input  logic                                      wr_en,
    input  logic [((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS > 1 ?
                   $clog2((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]                      wr_data,
    output logic                                      found,
    output logic [((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS > 1 ?
                   $clog2((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] word
);

    localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int FRAME_W   = $clog2(MAX_FRAMES + 1);
    localparam int FX        = FRAME_W + 1;

    logic [NUM_WORDS-1:0] full_reg;
    logic [NUM_WORDS-1:0] cand;
    logic                 found_next;
    logic [ADDR_W-1:0]    word_next;
    logic                 found_reg;
    logic [ADDR_W-1:0]    word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else if (wr_en)
        begin
            full_reg[wr_addr] <= &wr_data;
        end
    end

    // A word is a candidate when its first frame lies below the limit.
    for (genvar w = 0; w < NUM_WORDS; w++)
    begin : g_cand
        assign cand[w] = !full_reg[w] && (FX'(w * WORD_BITS) < FX'(limit));
    end

    always_comb
    begin
        found_next = 1'b0;
        word_next  = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found_next = 1'b1;
                word_next  = ADDR_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            word_reg  <= '0;
        end
        else
        begin
            found_reg <= found_next;
            word_reg  <= word_next;
        end
    end

    assign found = found_reg;
    assign word  = word_reg;

endmodule

// ----- rtl/core/fba_ctrl.sv -----
// ============================================================================
// fba_ctrl
// Request sequencer: captures a request, locates its bitmap word, reads it,
// modifies and writes it back, and registers the result.
// ============================================================================
`include "frame_bitmap_allocator_assert.svh"

module fba_ctrl #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
    parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF,
    parameter int PAGE_SHIFT = fba_pkg::PAGE_SHIFT_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic [fba_pkg::KIND_W-1:0]                kind,
    input  logic [fba_pkg::ADDR_BITS-1:0]             frame_address,
    input  logic [fba_pkg::FRAME_NUM_W-1:0]           page_frame,
    input  logic                                      kernel_page,
    input  logic                                      is_writable,
    input  logic [$clog2(MAX_FRAMES + 1)-1:0]         limit,
    input  logic                                      sum_found,
    input  logic [((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS > 1 ?
                   $clog2((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] sum_word,
    output logic                                      rd_en,
    output logic [((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS > 1 ?
                   $clog2((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] rd_addr,
    input  logic [WORD_BITS-1:0]                      rd_data,
    output logic                                      wr_en,
    output logic [((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS > 1 ?
                   $clog2((MAX_FRAMES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] wr_addr,
    output logic [WORD_BITS-1:0]                      wr_data,
    output logic                                      done,
    output fba_pkg::result_t                          result
);

    localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int FRAME_W   = $clog2(MAX_FRAMES + 1);
    localparam int PAGE_W    = fba_pkg::ADDR_BITS - PAGE_SHIFT;
    localparam int TGT_A     = (FRAME_W > PAGE_W) ? FRAME_W : PAGE_W;
    localparam int TGT_W     = (TGT_A > fba_pkg::FRAME_NUM_W) ? TGT_A : fba_pkg::FRAME_NUM_W;
    localparam int FX        = (FRAME_W + 1 > fba_pkg::FRAME_NUM_W) ?
                               FRAME_W + 1 : fba_pkg::FRAME_NUM_W;
    // Word index by multiplying with a rounded-up reciprocal; exact for TGT_W-bit frames.
    localparam int                  REC_K = TGT_W + BIT_W;
    localparam longint unsigned     REC_L = ((64'd1 << REC_K) + WORD_BITS - 1) / WORD_BITS;
    localparam logic [TGT_W:0]      RECIP = REC_L[TGT_W:0];
    localparam logic [TGT_W-1:0]    MAX_T = TGT_W'(MAX_FRAMES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FIND = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_MOD  = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [fba_pkg::KIND_W-1:0]       kind_reg;
    logic [fba_pkg::FRAME_NUM_W-1:0]  pframe_reg;
    logic                             kern_reg;
    logic                             wrt_reg;
    logic [TGT_W-1:0]                 target_reg, target_next;
    logic                             in_range_reg;
    logic [TGT_W-1:0]                 qword_reg;
    logic [2*TGT_W:0]                 prod;
    logic                             done_reg, done_next;
    fba_pkg::result_t                 res_reg, res_next;

    logic [TGT_W-1:0]                 qmul;
    logic [TGT_W-1:0]                 rem;
    logic [BIT_W-1:0]                 bit_idx;
    logic [WORD_BITS-1:0]             bit_mask;
    logic                             zero_found;
    logic [BIT_W-1:0]                 zero_idx;
    logic [FX-1:0]                    pick_frame;
    logic                             alloc_ok;
    logic                             accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        if (kind == fba_pkg::KIND_FREE)
        begin
            target_next = TGT_W'(page_frame);
        end
        else
        begin
            target_next = TGT_W'(frame_address >> PAGE_SHIFT);
        end
    end

    assign prod = target_reg * RECIP;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind;
            pframe_reg   <= page_frame;
            kern_reg     <= kernel_page;
            wrt_reg      <= is_writable;
            target_reg   <= target_next;
            in_range_reg <= (target_next < MAX_T);
        end
        if (state_reg == S_FIND)
        begin
            qword_reg <= prod[REC_K +: TGT_W];
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = accept ? S_FIND : S_IDLE;
            S_FIND:  state_next = S_READ;
            S_READ:  state_next = S_MOD;
            S_MOD:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign rd_en   = (state_reg == S_READ);
    assign rd_addr = (kind_reg == fba_pkg::KIND_ALLOC) ? sum_word : qword_reg[ADDR_W-1:0];

    // Bit position of the target frame inside its word.
    assign qmul     = TGT_W'(qword_reg * WORD_BITS);
    assign rem      = target_reg - qmul;
    assign bit_idx  = rem[BIT_W-1:0];
    assign bit_mask = WORD_BITS'(1) << bit_idx;

    // Lowest clear bit of the word that the summary picked.
    always_comb
    begin
        zero_found = 1'b0;
        zero_idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rd_data[i])
            begin
                zero_found = 1'b1;
                zero_idx   = BIT_W'(i);
            end
        end
    end

    assign pick_frame = FX'(FX'(sum_word) * FX'(WORD_BITS)) + FX'(zero_idx);
    assign alloc_ok   = sum_found && zero_found && (pick_frame < FX'(limit));

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = qword_reg[ADDR_W-1:0];
        wr_data   = rd_data;
        res_next  = '0;
        done_next = (state_reg == S_MOD);
        if (state_reg == S_MOD)
        begin
            case (kind_reg)
                fba_pkg::KIND_ALLOC:
                begin
                    if (pframe_reg != '0)
                    begin
                        res_next.frame_number = pframe_reg;
                    end
                    else if (alloc_ok)
                    begin
                        wr_en                 = 1'b1;
                        wr_addr               = sum_word;
                        wr_data               = rd_data | (WORD_BITS'(1) << zero_idx);
                        res_next.frame_number = pick_frame[fba_pkg::FRAME_NUM_W-1:0];
                        res_next.present      = 1'b1;
                        res_next.writable     = wrt_reg;
                        res_next.user_access  = !kern_reg;
                        res_next.page_updated = 1'b1;
                    end
                    else
                    begin
                        res_next.frame_number  = pframe_reg;
                        res_next.no_free_frame = 1'b1;
                    end
                end
                fba_pkg::KIND_FREE:
                begin
                    if (pframe_reg != '0)
                    begin
                        wr_en                 = in_range_reg;
                        wr_data               = rd_data & ~bit_mask;
                        res_next.page_updated = 1'b1;
                    end
                end
                fba_pkg::KIND_MARK:
                begin
                    wr_en   = in_range_reg;
                    wr_data = rd_data | bit_mask;
                end
                fba_pkg::KIND_CLEAR:
                begin
                    wr_en   = in_range_reg;
                    wr_data = rd_data & ~bit_mask;
                end
                fba_pkg::KIND_TEST:
                begin
                    res_next.frame_used = in_range_reg && ((rd_data & bit_mask) != '0);
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    `FBA_ASSERT_NEXT(a_mod_gives_result, state_reg == S_MOD, done_reg)
    `FBA_ASSERT_NOW(a_write_only_in_mod, wr_en, state_reg == S_MOD)
    `FBA_ASSERT_NOW(a_no_read_write_overlap, rd_en, !wr_en)
    `FBA_ASSERT_NOW(a_single_outcome, done_reg, !(res_reg.page_updated && res_reg.no_free_frame))

endmodule

// ----- rtl/core/frame_bitmap_allocator.sv -----
// ============================================================================
// frame_bitmap_allocator
// First-fit physical page-frame allocator over a usage bitmap held in a
// synchronous memory, with a full-word summary to locate free frames.
// ============================================================================
//
//  Channel   Ports                                              Transfer
//  --------  -------------------------------------------------  ----------------------
//  request   kind, frame_address, page_frame, kernel_page,      start high, busy low
//            is_writable
//  result    frame_number, present, writable, user_access,      done high, one cycle
//            page_updated, no_free_frame, frame_used
//  config    cfg_data (frames_in_use)                           cfg_write high
//
// Every request passes through the sequencer states in order: FIND locates the
// word (summary encoder and reciprocal multiply), READ reads the memory, MOD
// does the read-modify-write, and then the registered result is on the ports.
// A new request may be accepted in the same cycle that done is high; the
// sequencer works on one request at a time and takes no new one while busy.
// Reset is asynchronous and active low. The bitmap needs no clearing pass:
// per-word valid bits make every word read as free after reset. The receiver
// cannot stall; each result is offered for exactly one cycle.
//
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
    parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF,
    parameter int PAGE_SHIFT = fba_pkg::PAGE_SHIFT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [fba_pkg::KIND_W-1:0]      kind,
    input  logic [fba_pkg::ADDR_BITS-1:0]   frame_address,
    input  logic [fba_pkg::FRAME_NUM_W-1:0] page_frame,
    input  logic                            kernel_page,
    input  logic                            is_writable,
    output logic                            done,
    output logic [fba_pkg::FRAME_NUM_W-1:0] frame_number,
    output logic                            present,
    output logic                            writable,
    output logic                            user_access,
    output logic                            page_updated,
    output logic                            no_free_frame,
    output logic                            frame_used,
    input  logic                            cfg_write,
    input  logic [fba_pkg::CFG_W-1:0]       cfg_data
);

    localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int FRAME_W   = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W     = (FRAME_W > fba_pkg::CFG_W) ? FRAME_W : fba_pkg::CFG_W;

    logic [fba_pkg::CFG_W-1:0] frames_reg;
    logic [CMP_W-1:0]          limit_wide;
    logic [FRAME_W-1:0]        limit;

    logic                      sum_found;
    logic [ADDR_W-1:0]         sum_word;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic [WORD_BITS-1:0]      rd_data;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [WORD_BITS-1:0]      wr_data;
    fba_pkg::result_t          result;

    // Managed frame count; writes must happen only while no request is in flight, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= fba_pkg::FRAMES_RESET;
        end
        else if (cfg_write)
        begin
            frames_reg <= cfg_data;
        end
    end

    // A frame count above the bitmap size is treated as the bitmap size.
    assign limit_wide = (CMP_W'(frames_reg) > CMP_W'(MAX_FRAMES)) ?
                        CMP_W'(MAX_FRAMES) : CMP_W'(frames_reg);
    assign limit      = limit_wide[FRAME_W-1:0];

    fba_mem #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    fba_summary #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_summary (
        .clk     (clk),
        .rst_n   (rst_n),
        .limit   (limit),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .found   (sum_found),
        .word    (sum_word)
    );

    fba_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .frame_address (frame_address),
        .page_frame    (page_frame),
        .kernel_page   (kernel_page),
        .is_writable   (is_writable),
        .limit         (limit),
        .sum_found     (sum_found),
        .sum_word      (sum_word),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .done          (done),
        .result        (result)
    );

    // The result record fans out to the individual result ports.
    assign frame_number  = result.frame_number;
    assign present       = result.present;
    assign writable      = result.writable;
    assign user_access   = result.user_access;
    assign page_updated  = result.page_updated;
    assign no_free_frame = result.no_free_frame;
    assign frame_used    = result.frame_used;

endmodule

// ----- test/testbench.sv -----
// ============================================================================
// Frame bitmap allocator testbench
// Drives allocate, free, mark, clear and test requests into the allocator
// under several managed-frame counts. Results are checked field by field
// against a bitmap predictor that runs in lockstep with the accepted requests.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles to keep watching after the last result, to catch a stray strobe.
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_SETTING = 65;

    // Kinds with no meaning; the block must answer them with an all-zero result.
    localparam logic [fba_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [fba_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // Entries of the stimulus queue: a request, a register write, or a pause
    // that holds the sender off until every outstanding result has come back.
    typedef enum logic [1:0] {
        ENTRY_REQUEST,
        ENTRY_CONFIG,
        ENTRY_DRAIN
    } entry_kind_e;

    typedef struct {
        entry_kind_e                      entry;
        logic [fba_pkg::KIND_W-1:0]       kind;
        logic [fba_pkg::ADDR_BITS-1:0]    addr;
        logic [fba_pkg::FRAME_NUM_W-1:0]  pframe;
        logic                             kern;
        logic                             wr;
        logic [fba_pkg::CFG_W-1:0]        cfg_value;
    } request_t;

    // Clock, reset and every input of the block start at known values.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [fba_pkg::KIND_W-1:0] kind = '0;
    logic [fba_pkg::ADDR_BITS-1:0] frame_address = '0;
    logic [fba_pkg::FRAME_NUM_W-1:0] page_frame = '0;
    logic kernel_page = 1'b0;
    logic is_writable = 1'b0;
    logic cfg_write = 1'b0;
    logic [fba_pkg::CFG_W-1:0] cfg_data = '0;

    logic busy;
    logic done;
    logic [fba_pkg::FRAME_NUM_W-1:0] frame_number;
    logic present;
    logic writable;
    logic user_access;
    logic page_updated;
    logic no_free_frame;
    logic frame_used;

    // Predictor state: one usage bit per frame and the managed-frame count.
    bit [fba_pkg::MAX_FRAMES_DEF-1:0] frame_usage = '0;
    int frame_limit = int'(fba_pkg::FRAMES_RESET);

    request_t         pending_requests[$];
    fba_pkg::result_t expected_results[$];

    int requests_sent = 0;      // transfers accepted, owned by the driver
    int results_seen = 0;       // results strobed, owned by the monitor
    int error_count = 0;
    int cycle_count = 0;

    frame_bitmap_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .frame_address (frame_address),
        .page_frame    (page_frame),
        .kernel_page   (kernel_page),
        .is_writable   (is_writable),
        .done          (done),
        .frame_number  (frame_number),
        .present       (present),
        .writable      (writable),
        .user_access   (user_access),
        .page_updated  (page_updated),
        .no_free_frame (no_free_frame),
        .frame_used    (frame_used),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Each mismatch prints one line and is counted toward the verdict.
    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, int index, int unsigned got, int unsigned want);
        if (got != want)
        begin
            report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                      index, name, got, want));
        end
    endtask

    task automatic add_item(logic [fba_pkg::KIND_W-1:0] k, logic [fba_pkg::ADDR_BITS-1:0] a,
                            logic [fba_pkg::FRAME_NUM_W-1:0] pf, logic kern, logic wr);
        request_t r;
        r.entry = ENTRY_REQUEST;
        r.kind = k;
        r.addr = a;
        r.pframe = pf;
        r.kern = kern;
        r.wr = wr;
        r.cfg_value = '0;
        pending_requests.push_back(r);
    endtask

    // Applies one accepted request to the predicted bitmap and returns the
    // result the block should give for it. Allocation is first fit over the
    // managed frames; a count above the bitmap size is clamped to it.
    function automatic fba_pkg::result_t frame_outcome(request_t r);
        fba_pkg::result_t res;
        int unsigned addr_frame;
        int span;
        int found;
        int i;
        res = '0;
        addr_frame = r.addr >> fba_pkg::PAGE_SHIFT_DEF;
        case (r.kind)
            fba_pkg::KIND_ALLOC:
            begin
                if (r.pframe != '0)
                begin
                    // The page already holds a frame, so it is simply echoed.
                    res.frame_number = r.pframe;
                end
                else
                begin
                    span = (frame_limit > fba_pkg::MAX_FRAMES_DEF) ?
                           fba_pkg::MAX_FRAMES_DEF : frame_limit;
                    found = -1;
                    for (i = 0; i < span && found < 0; i++)
                    begin
                        if (!frame_usage[i])
                            found = i;
                    end
                    if (found >= 0)
                    begin
                        frame_usage[found] = 1'b1;
                        res.frame_number = found[fba_pkg::FRAME_NUM_W-1:0];
                        res.present = 1'b1;
                        res.writable = r.wr;
                        res.user_access = !r.kern;
                        res.page_updated = 1'b1;
                    end
                    else
                    begin
                        res.no_free_frame = 1'b1;
                    end
                end
            end
            fba_pkg::KIND_FREE:
            begin
                // A page frame of zero means the page holds nothing to free.
                if (r.pframe != '0)
                begin
                    frame_usage[r.pframe] = 1'b0;
                    res.page_updated = 1'b1;
                end
            end
            fba_pkg::KIND_MARK:
            begin
                if (addr_frame < fba_pkg::MAX_FRAMES_DEF)
                    frame_usage[addr_frame] = 1'b1;
            end
            fba_pkg::KIND_CLEAR:
            begin
                if (addr_frame < fba_pkg::MAX_FRAMES_DEF)
                    frame_usage[addr_frame] = 1'b0;
            end
            fba_pkg::KIND_TEST:
            begin
                if (addr_frame < fba_pkg::MAX_FRAMES_DEF)
                    res.frame_used = frame_usage[addr_frame];
            end
            default:
            begin
                // Spare kinds leave the bitmap alone and answer with zeros.
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. Takes entries from the pending queue in order. A request is
    // raised on start after its idle gap and held until a transfer (start high
    // while busy is low). Register writes and pauses wait until every request
    // sent so far has produced its result, so the block is idle at that point.
    // Each output gets a single nonblocking assignment per edge, so start stays
    // high without a glitch when one request follows another back to back.
    // ------------------------------------------------------------------------
    int gap_left = 0;
    int burst_left = 0;
    request_t in_flight;

    always @(posedge clk or negedge rst_n)
    begin : driver
        request_t head;
        logic start_next;
        logic cfg_write_next;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_write <= 1'b0;
        end
        else
        begin
            start_next = start;
            cfg_write_next = 1'b0;
            if (start && !busy)
            begin
                // The transfer happens at this edge; predict its result now,
                // in the order the block takes requests.
                expected_results.push_back(frame_outcome(in_flight));
                requests_sent++;
                start_next = 1'b0;
            end
            if (!start_next)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_requests.size() > 0)
                begin
                    head = pending_requests[0];
                    if (head.entry == ENTRY_REQUEST)
                    begin
                        void'(pending_requests.pop_front());
                        in_flight = head;
                        kind <= head.kind;
                        frame_address <= head.addr;
                        page_frame <= head.pframe;
                        kernel_page <= head.kern;
                        is_writable <= head.wr;
                        start_next = 1'b1;
                        // Draw the idle gap before the next request; now and
                        // then run a stretch of requests with no gap at all.
                        if (burst_left > 0)
                        begin
                            burst_left--;
                            gap_left = 0;
                        end
                        else
                        begin
                            if ($urandom_range(0, 24) == 0)
                                burst_left = $urandom_range(8, 20);
                            gap_left = $urandom_range(0, 9);
                        end
                    end
                    else if (requests_sent == results_seen)
                    begin
                        void'(pending_requests.pop_front());
                        if (head.entry == ENTRY_CONFIG)
                        begin
                            cfg_write_next = 1'b1;
                            cfg_data <= head.cfg_value;
                            frame_limit = int'(head.cfg_value);
                        end
                    end
                end
            end
            start <= start_next;
            cfg_write <= cfg_write_next;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. A result is on the ports for one cycle while done is high and
    // is taken at the edge that ends that cycle; it is compared field by field
    // with the oldest predicted result.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        fba_pkg::result_t want;
        if (!rst_n)
        begin
            results_seen <= 0;
        end
        else if (done)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                          results_seen));
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("frame_number", results_seen, 32'(frame_number),
                            32'(want.frame_number));
                check_field("present", results_seen, 32'(present), 32'(want.present));
                check_field("writable", results_seen, 32'(writable), 32'(want.writable));
                check_field("user_access", results_seen, 32'(user_access),
                            32'(want.user_access));
                check_field("page_updated", results_seen, 32'(page_updated),
                            32'(want.page_updated));
                check_field("no_free_frame", results_seen, 32'(no_free_frame),
                            32'(want.no_free_frame));
                check_field("frame_used", results_seen, 32'(frame_used),
                            32'(want.frame_used));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. A directed opening runs at the reset frame count, then each
    // setting of the frame count gets a stretch of random requests. Small
    // counts make the allocator run out of frames, so the no-free-frame path
    // is exercised; zero and the largest register value cover the extremes.
    // ------------------------------------------------------------------------
    int unsigned frame_settings[9] = '{40, 0, 1, 8191, 33, 4096, 5000, 100, 64};

    initial
    begin
        request_t r;
        int unsigned span;
        int unsigned pick;
        int unsigned target;
        int unsigned draw;
        logic [fba_pkg::KIND_W-1:0] k;
        logic [fba_pkg::ADDR_BITS-1:0] a;
        logic [fba_pkg::FRAME_NUM_W-1:0] pf;
        logic kern_bit;
        logic wr_bit;

        // Directed opening on an empty bitmap with every frame managed.
        add_item(fba_pkg::KIND_TEST, 32'h0000_0000, 12'h000, 1'b0, 1'b0);
        // Frame zero is free first, so it is handed out and returned as zero.
        add_item(fba_pkg::KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b0, 1'b1);
        add_item(fba_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 12'h000, 1'b1, 1'b0);
        // A page that already holds a frame keeps it and nothing changes.
        add_item(fba_pkg::KIND_ALLOC, 32'h0000_0000, 12'hFFF, 1'b1, 1'b1);
        add_item(fba_pkg::KIND_TEST, 32'h0000_1ABC, 12'h000, 1'b0, 1'b0);
        // Freeing a page that holds nothing is a no-op.
        add_item(fba_pkg::KIND_FREE, 32'hFFFF_FFFF, 12'h000, 1'b1, 1'b1);
        add_item(fba_pkg::KIND_FREE, 32'h0000_0000, 12'h001, 1'b0, 1'b0);
        add_item(fba_pkg::KIND_TEST, 32'h0000_1000, 12'h000, 1'b0, 1'b0);
        // Addresses past the bitmap are ignored and test as unused.
        add_item(fba_pkg::KIND_MARK, 32'hFFFF_FFFF, 12'h000, 1'b0, 1'b0);
        add_item(fba_pkg::KIND_TEST, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b1);
        add_item(fba_pkg::KIND_CLEAR, 32'h0100_0000, 12'h000, 1'b0, 1'b0);
        // The last frame of the bitmap: mark, test, clear, test.
        add_item(fba_pkg::KIND_MARK, 32'h00FF_F000, 12'h000, 1'b0, 1'b0);
        add_item(fba_pkg::KIND_TEST, 32'h00FF_FFFF, 12'h000, 1'b0, 1'b0);
        add_item(fba_pkg::KIND_CLEAR, 32'h00FF_F123, 12'h000, 1'b0, 1'b0);
        add_item(fba_pkg::KIND_TEST, 32'h00FF_F000, 12'h000, 1'b0, 1'b0);
        // First fit skips a marked frame.
        add_item(fba_pkg::KIND_MARK, 32'h0000_2FFF, 12'h000, 1'b0, 1'b0);
        add_item(fba_pkg::KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b0, 1'b1);
        add_item(fba_pkg::KIND_ALLOC, 32'h0000_0000, 12'h000, 1'b1, 1'b1);
        add_item(fba_pkg::KIND_FREE, 32'h0000_0000, 12'hFFF, 1'b0, 1'b0);
        add_item(fba_pkg::KIND_FREE, 32'h0000_0000, 12'h800, 1'b0, 1'b0);
        // Spare kinds with every other field at its maximum.
        add_item(KIND_SPARE_LO, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b1);
        add_item(KIND_SPARE_LO + 3'd1, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b1);
        add_item(KIND_SPARE_HI, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 1'b1);

        foreach (frame_settings[s])
        begin
            r.entry = ENTRY_CONFIG;
            r.cfg_value = frame_settings[s][fba_pkg::CFG_W-1:0];
            pending_requests.push_back(r);
            // Frames drawn reach a little past the managed count, so free,
            // mark and clear also touch unmanaged frames.
            span = frame_settings[s] + 8;
            if (span > fba_pkg::MAX_FRAMES_DEF - 1)
                span = fba_pkg::MAX_FRAMES_DEF - 1;
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                if (s == 3 && n == ITEMS_PER_SETTING / 2)
                begin
                    // Hold the sender off once mid-stream until all results are back.
                    r.entry = ENTRY_DRAIN;
                    pending_requests.push_back(r);
                end
                pick = $urandom_range(0, 99);
                target = $urandom_range(0, span);
                a = (target << fba_pkg::PAGE_SHIFT_DEF) |
                    $urandom_range(0, (1 << fba_pkg::PAGE_SHIFT_DEF) - 1);
                if ($urandom_range(0, 9) == 0)
                    a = $urandom;
                pf = target[fba_pkg::FRAME_NUM_W-1:0];
                if ($urandom_range(0, 6) == 0)
                begin
                    draw = $urandom;
                    pf = draw[fba_pkg::FRAME_NUM_W-1:0];
                end
                if (pick < 35)
                begin
                    k = fba_pkg::KIND_ALLOC;
                    // Mostly empty pages, so allocation actually takes frames.
                    if ($urandom_range(0, 4) != 0)
                        pf = '0;
                end
                else if (pick < 55)
                    k = fba_pkg::KIND_FREE;
                else if (pick < 70)
                    k = fba_pkg::KIND_MARK;
                else if (pick < 80)
                    k = fba_pkg::KIND_CLEAR;
                else if (pick < 95)
                    k = fba_pkg::KIND_TEST;
                else
                begin
                    draw = $urandom_range(KIND_SPARE_LO, KIND_SPARE_HI);
                    k = draw[fba_pkg::KIND_W-1:0];
                end
                draw = $urandom_range(0, 1);
                kern_bit = draw[0];
                draw = $urandom_range(0, 1);
                wr_bit = draw[0];
                add_item(k, a, pf, kern_bit, wr_bit);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Let every queued entry go out and every result come back.
        @(posedge clk);
        while (pending_requests.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
